// ===== rtl/hlfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hlfp_pkg
// Types and constants for the hold list frame parser.
// ----------------------------------------------------------------------------
package hlfp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;

	localparam logic [16:0] VALUE_SAT = 17'd65536;

	typedef enum logic [2:0] {
		KIND_HOLD        = 3'd0,
		KIND_PROBLEM_END = 3'd1,
		KIND_CFG_START   = 3'd2,
		KIND_CFG_BYTE    = 3'd3,
		KIND_CFG_END     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_LETTER = 2'd0,
		PH_PRE    = 2'd1,
		PH_SIGNED = 2'd2,
		PH_DIGITS = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]  config_char;
		logic        problem_valid;
		logic [15:0] hold_position;
		logic [7:0]  hold_letter;
		kind_t       kind;
		logic        last;
	} result_t;

	function automatic logic is_hold_letter(input logic [7:0] c);
		return c == CH_E || c == CH_F || c == CH_L || c == CH_M ||
			c == CH_P || c == CH_R || c == CH_S;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ===== rtl/hold_list_frame_parser.sv =====
// ----------------------------------------------------------------------------
// hold_list_frame_parser
// Byte-serial parser for framed hold lists with an embedded config channel.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received ASCII byte per transaction in tdata[7:0].
//   m_axis carries parsed results; tuser is the result kind, tlast marks the
//   last result caused by one input byte (a closing '#' may cause two).
//   A byte is registered on accept and decoded against the parser state once
//   the queue has room; its results are written into a four-entry output queue.
//   Results pass through the input register and the output queue to m_axis.
//   Throughput: one byte per cycle while each byte yields at most one result
//   and m_axis_tready stays high; a byte yielding two results occupies the single
//   output port for both of them, so the output port sets the sustained rate.
//   Decoding waits while fewer than two queue entries are free, and s_axis
//   ready drops only when the input register is full and cannot advance.
//   A stalled receiver therefore backs up into the input after the queue
//   fills. Reset empties the queue and returns the parser to the state
//   outside any frame.
// ----------------------------------------------------------------------------
module hold_list_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [7:0] hold_letter, [23:8] hold_position,
	                                   // [24] problem_valid, [32:25] config_char
	output logic [2:0]  m_axis_tuser,  // [2:0] kind
	output logic        m_axis_tlast   // last_of_run
);

	localparam int unsigned QUEUE_DEPTH = hlfp_pkg::QUEUE_DEPTH;
	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  advance;

	logic                  in_config_q;
	logic                  in_problem_q;
	hlfp_pkg::phase_t      phase_q;
	logic                  neg_q;
	logic [16:0]           value_q;
	logic [7:0]            letter_q;
	logic                  err_q;

	logic                  in_config_d;
	logic                  in_problem_d;
	hlfp_pkg::phase_t      phase_d;
	logic                  neg_d;
	logic [16:0]           value_d;
	logic [7:0]            letter_d;
	logic                  err_d;

	hlfp_pkg::result_t     res0;
	hlfp_pkg::result_t     res1;
	logic [1:0]            res_cnt;

	hlfp_pkg::result_t     queue_q [QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;
	logic                  pop;
	logic [1:0]            push_n;

	logic                  tok_valid;
	logic                  is_digit;
	logic [19:0]           value_x10;
	logic [19:0]           value_sum;
	hlfp_pkg::result_t     hold_res;
	hlfp_pkg::result_t     blank_res;
	hlfp_pkg::result_t     head;

	assign advance       = valid_s1 && (count_q <= CW'(QUEUE_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	assign tok_valid = (phase_q == hlfp_pkg::PH_DIGITS) && !value_q[16] &&
		!(neg_q && value_q != 17'd0);
	assign is_digit  = byte_s1 >= hlfp_pkg::CH_ZERO && byte_s1 <= hlfp_pkg::CH_NINE;
	assign value_x10 = {value_q, 3'b000} + {2'b00, value_q, 1'b0};
	assign value_sum = value_x10 + {16'd0, byte_s1[3:0]};

	always_comb begin
		blank_res               = '0;
		blank_res.kind          = hlfp_pkg::KIND_HOLD;
		hold_res                = blank_res;
		hold_res.hold_letter    = letter_q;
		hold_res.hold_position  = value_q[15:0];
	end

	// decode of one byte against the parser state
	always_comb begin
		in_config_d  = in_config_q;
		in_problem_d = in_problem_q;
		phase_d      = phase_q;
		neg_d        = neg_q;
		value_d      = value_q;
		letter_d     = letter_q;
		err_d        = err_q;
		res0         = blank_res;
		res1         = blank_res;
		res_cnt      = 2'd0;
		priority if (byte_s1 == hlfp_pkg::CH_TILDE) begin
			in_config_d      = 1'b1;
			res0.kind        = hlfp_pkg::KIND_CFG_START;
			res0.config_char = byte_s1;
			res0.last        = 1'b1;
			res_cnt          = 2'd1;
		end else if (in_config_q) begin
			res0.config_char = byte_s1;
			res0.last        = 1'b1;
			res_cnt          = 2'd1;
			if (byte_s1 == hlfp_pkg::CH_STAR) begin
				in_config_d = 1'b0;
				res0.kind   = hlfp_pkg::KIND_CFG_END;
			end else begin
				res0.kind   = hlfp_pkg::KIND_CFG_BYTE;
			end
		end else if (byte_s1 == hlfp_pkg::CH_HASH) begin
			in_problem_d = !in_problem_q;
			err_d        = 1'b0;
			phase_d      = hlfp_pkg::PH_LETTER;
			neg_d        = 1'b0;
			value_d      = '0;
			letter_d     = '0;
			if (in_problem_q) begin
				if (!err_q && tok_valid) begin
					res0               = hold_res;
					res1.kind          = hlfp_pkg::KIND_PROBLEM_END;
					res1.problem_valid = 1'b1;
					res1.last          = 1'b1;
					res_cnt            = 2'd2;
				end else begin
					res0.kind          = hlfp_pkg::KIND_PROBLEM_END;
					res0.last          = 1'b1;
					res_cnt            = 2'd1;
				end
			end
		end else if (in_problem_q) begin
			if (byte_s1 == hlfp_pkg::CH_COMMA) begin
				phase_d  = hlfp_pkg::PH_LETTER;
				neg_d    = 1'b0;
				value_d  = '0;
				letter_d = '0;
				if (!err_q) begin
					if (tok_valid) begin
						res0      = hold_res;
						res0.last = 1'b1;
						res_cnt   = 2'd1;
					end else begin
						err_d = 1'b1;
					end
				end
			end else if (!err_q) begin
				unique case (phase_q)
					hlfp_pkg::PH_LETTER: begin
						if (hlfp_pkg::is_hold_letter(byte_s1)) begin
							letter_d = byte_s1;
							phase_d  = hlfp_pkg::PH_PRE;
						end else begin
							err_d = 1'b1;
						end
					end
					default: begin
						if (phase_q == hlfp_pkg::PH_PRE && hlfp_pkg::is_space(byte_s1)) begin
							phase_d = phase_q;
						end else if (phase_q == hlfp_pkg::PH_PRE &&
							(byte_s1 == hlfp_pkg::CH_PLUS ||
							 byte_s1 == hlfp_pkg::CH_MINUS)) begin
							neg_d   = byte_s1 == hlfp_pkg::CH_MINUS;
							phase_d = hlfp_pkg::PH_SIGNED;
						end else if (is_digit) begin
							value_d = (value_sum > {3'b000, hlfp_pkg::VALUE_SAT}) ?
								hlfp_pkg::VALUE_SAT : value_sum[16:0];
							phase_d = hlfp_pkg::PH_DIGITS;
						end else begin
							err_d = 1'b1;
						end
					end
				endcase
			end
		end else begin
			// bytes outside any frame are dropped
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_config_q  <= 1'b0;
			in_problem_q <= 1'b0;
			phase_q      <= hlfp_pkg::PH_LETTER;
			neg_q        <= 1'b0;
			value_q      <= '0;
			letter_q     <= '0;
			err_q        <= 1'b0;
		end else if (advance) begin
			in_config_q  <= in_config_d;
			in_problem_q <= in_problem_d;
			phase_q      <= phase_d;
			neg_q        <= neg_d;
			value_q      <= value_d;
			letter_q     <= letter_d;
			err_q        <= err_d;
		end
	end

	// output queue
	assign push_n = advance ? res_cnt : 2'd0;
	assign pop    = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			queue_q[PW'(wr_ptr_q + PW'(1))] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PW'(wr_ptr_q + PW'(push_n));
			rd_ptr_q <= PW'(rd_ptr_q + PW'(pop));
			count_q  <= CW'(count_q + CW'(push_n) - CW'(pop));
		end
	end

	assign head          = queue_q[rd_ptr_q];
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;
	assign m_axis_tdata  = {7'd0, head.config_char, head.problem_valid,
		head.hold_position, head.hold_letter};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("output queue overflow");

	a_only_hold_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != hlfp_pkg::KIND_HOLD |-> m_axis_tlast)
		else $error("non-hold result not last of run");

	a_hold_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == hlfp_pkg::KIND_HOLD |->
		hlfp_pkg::is_hold_letter(m_axis_tdata[7:0]))
		else $error("hold result with bad letter");

	a_tilde_config: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1 == hlfp_pkg::CH_TILDE |=> in_config_q)
		else $error("tilde did not enter configuration");
`endif

endmodule
